/* sv/acpi_power_state_sequencer_defines.svh */
// Assertion macros for the power state sequencer RTL.
`ifndef ACPI_POWER_STATE_SEQUENCER_DEFINES_SVH
`define ACPI_POWER_STATE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define APSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apss assertion failed");
// Next-cycle implication, checked outside reset.
`define APSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apss assertion failed");
`else
`define APSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define APSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/apss_pkg.sv */
// Types, codes and helpers for the power state sequencer.
package apss_pkg;

    localparam int CNT_W   = 16;
    localparam int CODE_W  = 4;
    localparam int HOOK_W  = 3;
    localparam int RADIO_W = 2;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SPOK_WAIT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PWROK_DELAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_RESET_PULSE = 2'd2;
    localparam logic [IDX_W-1:0] REG_G3_RAIL     = 2'd3;

    localparam logic [CNT_W-1:0] SPOK_WAIT_RST   = 16'd1000;
    localparam logic [CNT_W-1:0] PWROK_DELAY_RST = 16'd1;
    localparam logic [CNT_W-1:0] RESET_PULSE_RST = 16'd32;

    // Reported power state codes
    localparam logic [CODE_W-1:0] PS_G3   = 4'd0;
    localparam logic [CODE_W-1:0] PS_G3S5 = 4'd1;
    localparam logic [CODE_W-1:0] PS_S5   = 4'd2;
    localparam logic [CODE_W-1:0] PS_S5S3 = 4'd3;
    localparam logic [CODE_W-1:0] PS_S3   = 4'd4;
    localparam logic [CODE_W-1:0] PS_S3S0 = 4'd5;
    localparam logic [CODE_W-1:0] PS_S0   = 4'd6;
    localparam logic [CODE_W-1:0] PS_S0S3 = 4'd7;
    localparam logic [CODE_W-1:0] PS_S3S5 = 4'd8;
    localparam logic [CODE_W-1:0] PS_S5G3 = 4'd9;

    localparam logic [RADIO_W-1:0] RADIO_OFF     = 2'd0;
    localparam logic [RADIO_W-1:0] RADIO_SUSPEND = 2'd1;
    localparam logic [RADIO_W-1:0] RADIO_ON      = 2'd2;

    typedef enum logic [9:0] {
        ST_G3   = 10'b00_0000_0001,
        ST_G3S5 = 10'b00_0000_0010,
        ST_S5   = 10'b00_0000_0100,
        ST_S5S3 = 10'b00_0000_1000,
        ST_S3   = 10'b00_0001_0000,
        ST_S3S0 = 10'b00_0010_0000,
        ST_S0   = 10'b00_0100_0000,
        ST_S0S3 = 10'b00_1000_0000,
        ST_S3S5 = 10'b01_0000_0000,
        ST_S5G3 = 10'b10_0000_0000
    } state_t;

    typedef enum logic [HOOK_W-1:0] {
        HK_NONE     = 3'd0,
        HK_PREINIT  = 3'd1,
        HK_STARTUP  = 3'd2,
        HK_RESUME   = 3'd3,
        HK_SUSPEND  = 3'd4,
        HK_SHUTDOWN = 3'd5
    } hook_t;

    typedef struct packed {
        logic [CNT_W-1:0] spok_wait_ticks;
        logic [CNT_W-1:0] pwrok_delay_ticks;
        logic [CNT_W-1:0] reset_pulse_ticks;
        logic             g3_rail_control;
    } cfg_t;

    typedef struct packed {
        logic spok;
        logic vgate;
        logic sleep_s5_n;
        logic sleep_s3_n;
        logic power_up_request;
        logic shutdown_request;
        logic warm_reset_request;
        logic throttle_request;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  sys_state;
        logic               resume_reset_n;
        logic               system_power_ok;
        logic               rail_enable;
        logic               button_pressed;
        logic               reset_line_n;
        logic               cpu_hot;
        hook_t              hook_event;
        logic [RADIO_W-1:0] radio_mode;
        logic               deep_sleep_ok;
    } result_t;

    function automatic logic [CODE_W-1:0] state_code(input state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_G3:   code = PS_G3;
            ST_G3S5: code = PS_G3S5;
            ST_S5:   code = PS_S5;
            ST_S5S3: code = PS_S5S3;
            ST_S3:   code = PS_S3;
            ST_S3S0: code = PS_S3S0;
            ST_S0:   code = PS_S0;
            ST_S0S3: code = PS_S0S3;
            ST_S3S5: code = PS_S3S5;
            ST_S5G3: code = PS_S5G3;
            default: code = PS_G3;
        endcase
        return code;
    endfunction

    // S3S0, S0 and S0S3 are the on states.
    function automatic logic is_on(input state_t st);
        return (st == ST_S3S0) || (st == ST_S0) || (st == ST_S0S3);
    endfunction

    // G3, G3S5, S5, S5S3, S3S5 and S5G3 are the off states; S3 is neither.
    function automatic logic is_off(input state_t st);
        return (st == ST_G3) || (st == ST_G3S5) || (st == ST_S5) ||
               (st == ST_S5S3) || (st == ST_S3S5) || (st == ST_S5G3);
    endfunction

endpackage

/* sv/apss_cfg.sv */
// Configuration register file of the power state sequencer.
module apss_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [apss_pkg::IDX_W-1:0] cfg_index,
    input  logic [apss_pkg::CNT_W-1:0] cfg_data,
    output apss_pkg::cfg_t             cfg
);
    import apss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPOK_WAIT:   cfg_next.spok_wait_ticks   = cfg_data;
                REG_PWROK_DELAY: cfg_next.pwrok_delay_ticks = cfg_data;
                REG_RESET_PULSE: cfg_next.reset_pulse_ticks = cfg_data;
                REG_G3_RAIL:     cfg_next.g3_rail_control   = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spok_wait_ticks   <= SPOK_WAIT_RST;
            cfg_reg.pwrok_delay_ticks <= PWROK_DELAY_RST;
            cfg_reg.reset_pulse_ticks <= RESET_PULSE_RST;
            cfg_reg.g3_rail_control   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/apss_seq.sv */
// Sequencer state, counters and pin state; advances one tick per step.
`include "acpi_power_state_sequencer_defines.svh"

module apss_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  apss_pkg::item_t   item,
    input  apss_pkg::cfg_t    cfg,
    output apss_pkg::result_t result
);
    import apss_pkg::*;

    state_t             state_reg,    state_next;
    logic               pending_reg,  pending_next;
    logic [CNT_W-1:0]   spok_cnt_reg, spok_cnt_next;
    logic [CNT_W-1:0]   pwr_cnt_reg,  pwr_cnt_next;
    logic [CNT_W-1:0]   rst_cnt_reg,  rst_cnt_next;
    logic               pwrok_reg,    pwrok_next;
    logic               rail_reg,     rail_next;
    logic               button_reg,   button_next;
    logic               rcin_reg,     rcin_next;
    logic               hot_reg,      hot_next;
    logic [RADIO_W-1:0] radio_reg,    radio_next;
    logic               dsleep_reg,   dsleep_next;
    hook_t              hook;
    logic [CNT_W-1:0]   spok_cnt_inc;
    logic               now_on;
    logic               now_up;

    assign spok_cnt_inc = spok_cnt_reg + 1'b1;
    assign now_on       = is_on(state_next);
    assign now_up       = !is_off(state_next);

    always_comb
    begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        spok_cnt_next = spok_cnt_reg;
        pwr_cnt_next  = pwr_cnt_reg;
        rst_cnt_next  = rst_cnt_reg;
        pwrok_next    = pwrok_reg;
        rail_next     = rail_reg;
        button_next   = button_reg;
        rcin_next     = rcin_reg;
        hot_next      = hot_reg;
        radio_next    = radio_reg;
        dsleep_next   = dsleep_reg;
        hook          = HK_NONE;

        // power good: drops at once, rises after a steady delay
        if (!(item.vgate && item.spok))
        begin
            pwrok_next   = 1'b0;
            pwr_cnt_next = '0;
        end
        else if (!pwrok_reg)
        begin
            if (pwr_cnt_reg >= cfg.pwrok_delay_ticks)
            begin
                pwrok_next   = 1'b1;
                pwr_cnt_next = '0;
            end
            else
            begin
                pwr_cnt_next = pwr_cnt_reg + 1'b1;
            end
        end

        if ((state_reg == ST_S5) && pending_reg)
        begin
            button_next  = 1'b0;
            pending_next = 1'b0;
        end

        // G3S5 and S5G3 are off states, so dropping to G3 without rail
        // control never presses the button.
        case (state_reg)
            ST_G3:
            begin
                if (item.power_up_request)
                    state_next = ST_G3S5;
            end
            ST_G3S5:
            begin
                if (spok_cnt_reg == '0)
                begin
                    if (cfg.g3_rail_control)
                        rail_next = 1'b1;
                    hook = HK_PREINIT;
                end
                if (item.spok)
                begin
                    spok_cnt_next = '0;
                    state_next    = ST_S5;
                end
                else if (spok_cnt_inc >= cfg.spok_wait_ticks)
                begin
                    spok_cnt_next = '0;
                    if (cfg.g3_rail_control)
                        rail_next = 1'b0;
                    state_next = ST_G3;
                end
                else
                begin
                    spok_cnt_next = spok_cnt_inc;
                end
            end
            ST_S5:
            begin
                if (!item.spok)
                    state_next = ST_S5G3;
                else if (item.sleep_s5_n)
                    state_next = ST_S5S3;
            end
            ST_S5S3:
            begin
                if (!item.spok)
                    state_next = ST_S5G3;
                else
                begin
                    hook       = HK_STARTUP;
                    state_next = ST_S3;
                end
            end
            ST_S3:
            begin
                if (!item.spok)
                    state_next = ST_S5G3;
                else if (item.sleep_s3_n)
                    state_next = ST_S3S0;
                else if (!item.sleep_s5_n)
                    state_next = ST_S3S5;
            end
            ST_S3S0:
            begin
                if (!item.spok)
                    state_next = ST_S5G3;
                else
                begin
                    radio_next  = RADIO_ON;
                    hook        = HK_RESUME;
                    dsleep_next = 1'b0;
                    state_next  = ST_S0;
                end
            end
            ST_S0:
            begin
                if (!item.spok)
                    state_next = ST_S5G3;
                else if (!item.sleep_s3_n)
                    state_next = ST_S0S3;
            end
            ST_S0S3:
            begin
                hook        = HK_SUSPEND;
                radio_next  = RADIO_SUSPEND;
                dsleep_next = 1'b1;
                state_next  = ST_S3;
            end
            ST_S3S5:
            begin
                hook       = HK_SHUTDOWN;
                radio_next = RADIO_OFF;
                state_next = ST_S5;
            end
            ST_S5G3:
            begin
                if (cfg.g3_rail_control)
                    rail_next = 1'b0;
                state_next = ST_G3;
            end
            default:
            begin
                state_next = ST_G3;
            end
        endcase

        // requests are judged against the new state; shutdown and warm reset
        // act in any state that is not off (S3 included), throttle only when on
        if (item.shutdown_request && now_up)
        begin
            pending_next = 1'b1;
            button_next  = 1'b1;
        end

        if (now_on)
            hot_next = item.throttle_request;

        if (rst_cnt_reg != '0)
        begin
            rst_cnt_next = rst_cnt_reg - 1'b1;
            if (rst_cnt_next == '0)
                rcin_next = 1'b1;
        end
        if (item.warm_reset_request && now_up)
        begin
            rst_cnt_next = (cfg.reset_pulse_ticks != '0) ? cfg.reset_pulse_ticks
                                                          : CNT_W'(1);
            rcin_next    = 1'b0;
        end
    end

    always_comb
    begin
        result.sys_state       = state_code(state_next);
        result.resume_reset_n  = item.spok;
        result.system_power_ok = pwrok_next;
        result.rail_enable     = rail_next;
        result.button_pressed  = button_next;
        result.reset_line_n    = rcin_next;
        result.cpu_hot         = hot_next;
        result.hook_event      = hook;
        result.radio_mode      = radio_next;
        result.deep_sleep_ok   = dsleep_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_G3;
            pending_reg  <= 1'b0;
            spok_cnt_reg <= '0;
            pwr_cnt_reg  <= '0;
            rst_cnt_reg  <= '0;
            pwrok_reg    <= 1'b0;
            rail_reg     <= 1'b0;
            button_reg   <= 1'b0;
            rcin_reg     <= 1'b1;
            hot_reg      <= 1'b0;
            radio_reg    <= RADIO_OFF;
            dsleep_reg   <= 1'b1;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            spok_cnt_reg <= spok_cnt_next;
            pwr_cnt_reg  <= pwr_cnt_next;
            rst_cnt_reg  <= rst_cnt_next;
            pwrok_reg    <= pwrok_next;
            rail_reg     <= rail_next;
            button_reg   <= button_next;
            rcin_reg     <= rcin_next;
            hot_reg      <= hot_next;
            radio_reg    <= radio_next;
            dsleep_reg   <= dsleep_next;
        end
    end

    // the reset line is low only while the pulse counter runs
    `APSS_ASSERT_NOW(a_rcin_cnt, clk, rst_n, !rcin_reg, rst_cnt_reg != '0)
    // a pending forced shutdown always holds the button
    `APSS_ASSERT_NOW(a_pend_btn, clk, rst_n, pending_reg, button_reg)
    // power good is never high with the delay counter running
    `APSS_ASSERT_NOW(a_pwrok_cnt, clk, rst_n, pwrok_reg, pwr_cnt_reg == '0)
    // the spok wait counter only runs in G3S5
    `APSS_ASSERT_NOW(a_spok_cnt, clk, rst_n, spok_cnt_reg != '0, state_reg == ST_G3S5)

endmodule

/* sv/acpi_power_state_sequencer.sv */
// Top level of the power state sequencer: stream ports, input and result stages.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tdata[7:0]: one tick of pin samples
//  m_*     | out       | m_tvalid / m_tready | m_tdata[15:0]: state and pin outputs
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// Each tick request passes an input and a result register; the step logic between
// them takes one request per cycle when not stalled. cfg_ready is always high;
// configuration must be written with no request in flight, which the block does
// not enforce. Reset puts the sequencer in G3 with the reset line high and deep
// sleep allowed. A stall on m_tready holds the result; the input register still
// takes one more request, so the source only stalls once both stages are full.
module acpi_power_state_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] spok, [1] vgate, [2] sleep_s5_n, [3] sleep_s3_n, [4] power_up_request,
    // [5] shutdown_request, [6] warm_reset_request, [7] throttle_request
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] sys_state, [4] resume_reset_n, [5] system_power_ok, [6] rail_enable,
    // [7] button_pressed, [8] reset_line_n, [9] cpu_hot, [12:10] hook_event,
    // [14:13] radio_mode, [15] deep_sleep_ok
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import apss_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    step;

    apss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result stage free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.spok               <= s_tdata[0];
            item_reg.vgate              <= s_tdata[1];
            item_reg.sleep_s5_n         <= s_tdata[2];
            item_reg.sleep_s3_n         <= s_tdata[3];
            item_reg.power_up_request   <= s_tdata[4];
            item_reg.shutdown_request   <= s_tdata[5];
            item_reg.warm_reset_request <= s_tdata[6];
            item_reg.throttle_request   <= s_tdata[7];
        end
    end

    apss_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res)
    );

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.deep_sleep_ok, res_reg.radio_mode, res_reg.hook_event,
                       res_reg.cpu_hot, res_reg.reset_line_n, res_reg.button_pressed,
                       res_reg.rail_enable, res_reg.system_power_ok,
                       res_reg.resume_reset_n, res_reg.sys_state};

endmodule

/* tb/sv/acpi_power_state_sequencer_tb.sv */
// Self-checking stream testbench for the ACPI power state sequencer.
module acpi_power_state_sequencer_tb;
    import apss_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 144;
    localparam int REPORT_MAX  = 10;

    // Tracks the sequencer tick by tick and holds the pin reports still due.
    class sequencer_scoreboard;
        logic [CNT_W-1:0]  spok_wait_ticks;
        logic [CNT_W-1:0]  pwrok_delay_ticks;
        logic [CNT_W-1:0]  reset_pulse_ticks;
        logic              g3_rail_control;

        logic [CODE_W-1:0] cur_state;
        logic              shutdown_pending;
        logic [CNT_W-1:0]  spok_wait_count;
        logic [CNT_W-1:0]  pwrok_delay_count;
        logic [CNT_W-1:0]  reset_pulse_count;
        logic              rsmrst, pwrok, rail, button, rcin, hot, dsleep;
        logic [RADIO_W-1:0] radio;

        result_t reports_due[$];
        logic [9:0] seen_states;
        int failures;
        int compared;
        int pulses_started;

        function new();
            spok_wait_ticks   = SPOK_WAIT_RST;
            pwrok_delay_ticks = PWROK_DELAY_RST;
            reset_pulse_ticks = RESET_PULSE_RST;
            g3_rail_control   = 1'b1;
            cur_state         = PS_G3;
            shutdown_pending  = 1'b0;
            spok_wait_count   = '0;
            pwrok_delay_count = '0;
            reset_pulse_count = '0;
            rsmrst = 1'b0;
            pwrok  = 1'b0;
            rail   = 1'b0;
            button = 1'b0;
            rcin   = 1'b1;
            hot    = 1'b0;
            radio  = RADIO_OFF;
            dsleep = 1'b1;
            seen_states = 10'b1;
            failures = 0;
            compared = 0;
            pulses_started = 0;
        endfunction

        function bit powered(input logic [CODE_W-1:0] code);
            return (code == PS_S3S0) || (code == PS_S0) || (code == PS_S0S3);
        endfunction

        // Anything but the off states; S3 counts as awake here.
        function bit awake(input logic [CODE_W-1:0] code);
            return !((code == PS_G3) || (code == PS_G3S5) || (code == PS_S5) ||
                     (code == PS_S5S3) || (code == PS_S3S5) || (code == PS_S5G3));
        endfunction

        // Button press only takes effect while the SoC is not off.
        function void press_button(input logic [CODE_W-1:0] code);
            if (awake(code))
            begin
                shutdown_pending = 1'b1;
                button = 1'b1;
            end
        endfunction

        function void drop_to_g3(input logic [CODE_W-1:0] code);
            if (g3_rail_control)
                rail = 1'b0;
            else
                press_button(code);
        endfunction

        function void write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
            case (idx)
                REG_SPOK_WAIT:   spok_wait_ticks   = data;
                REG_PWROK_DELAY: pwrok_delay_ticks = data;
                REG_RESET_PULSE: reset_pulse_ticks = data;
                REG_G3_RAIL:     g3_rail_control   = data[0];
                default: ;
            endcase
        endfunction

        // One accepted tick: advance the model and queue the report it owes.
        function void note_tick(input logic [7:0] d);
            logic spok, vgate, s5n, s3n, up, sd, wr, thr;
            logic [CODE_W-1:0] nxt;
            hook_t hook;
            result_t due;
            {thr, wr, sd, up, s3n, s5n, vgate, spok} = d;
            hook = HK_NONE;
            nxt = cur_state;

            rsmrst = spok;
            if (!(vgate && spok))
            begin
                pwrok = 1'b0;
                pwrok_delay_count = '0;
            end
            else if (!pwrok)
            begin
                if (pwrok_delay_count >= pwrok_delay_ticks)
                begin
                    pwrok = 1'b1;
                    pwrok_delay_count = '0;
                end
                else
                    pwrok_delay_count = pwrok_delay_count + 1'b1;
            end

            if (cur_state == PS_S5 && shutdown_pending)
            begin
                button = 1'b0;
                shutdown_pending = 1'b0;
            end

            case (cur_state)
                PS_G3:
                    if (up)
                        nxt = PS_G3S5;
                PS_G3S5:
                begin
                    if (spok_wait_count == 0)
                    begin
                        if (g3_rail_control)
                            rail = 1'b1;
                        hook = HK_PREINIT;
                    end
                    if (spok)
                    begin
                        spok_wait_count = '0;
                        nxt = PS_S5;
                    end
                    else
                    begin
                        spok_wait_count = spok_wait_count + 1'b1;
                        if (spok_wait_count >= spok_wait_ticks)
                        begin
                            spok_wait_count = '0;
                            drop_to_g3(cur_state);
                            nxt = PS_G3;
                        end
                    end
                end
                PS_S5:
                    if (!spok)
                        nxt = PS_S5G3;
                    else if (s5n)
                        nxt = PS_S5S3;
                PS_S5S3:
                    if (!spok)
                        nxt = PS_S5G3;
                    else
                    begin
                        hook = HK_STARTUP;
                        nxt = PS_S3;
                    end
                PS_S3:
                    if (!spok)
                        nxt = PS_S5G3;
                    else if (s3n)
                        nxt = PS_S3S0;
                    else if (!s5n)
                        nxt = PS_S3S5;
                PS_S3S0:
                    if (!spok)
                        nxt = PS_S5G3;
                    else
                    begin
                        radio = RADIO_ON;
                        hook = HK_RESUME;
                        dsleep = 1'b0;
                        nxt = PS_S0;
                    end
                PS_S0:
                    if (!spok)
                        nxt = PS_S5G3;
                    else if (!s3n)
                        nxt = PS_S0S3;
                PS_S0S3:
                begin
                    hook = HK_SUSPEND;
                    radio = RADIO_SUSPEND;
                    dsleep = 1'b1;
                    nxt = PS_S3;
                end
                PS_S3S5:
                begin
                    hook = HK_SHUTDOWN;
                    radio = RADIO_OFF;
                    nxt = PS_S5;
                end
                PS_S5G3:
                begin
                    drop_to_g3(cur_state);
                    nxt = PS_G3;
                end
                default:
                    nxt = PS_G3;
            endcase
            cur_state = nxt;
            seen_states[nxt] = 1'b1;

            // Requests are judged against the state just entered.
            if (sd)
                press_button(cur_state);
            if (powered(cur_state))
                hot = thr;
            if (reset_pulse_count > 0)
            begin
                reset_pulse_count = reset_pulse_count - 1'b1;
                if (reset_pulse_count == 0)
                    rcin = 1'b1;
            end
            if (wr && awake(cur_state))
            begin
                reset_pulse_count = (reset_pulse_ticks != 0) ? reset_pulse_ticks : 16'd1;
                rcin = 1'b0;
                pulses_started++;
            end

            due.sys_state       = cur_state;
            due.resume_reset_n  = rsmrst;
            due.system_power_ok = pwrok;
            due.rail_enable     = rail;
            due.button_pressed  = button;
            due.reset_line_n    = rcin;
            due.cpu_hot         = hot;
            due.hook_event      = hook;
            due.radio_mode      = radio;
            due.deep_sleep_ok   = dsleep;
            reports_due.push_back(due);
        endfunction

        function void fail_note();
            failures++;
        endfunction

        // One accepted report, checked against the oldest one due.
        function void check_result(input logic [15:0] d);
            result_t got;
            result_t due;
            string bad;
            got.sys_state       = d[3:0];
            got.resume_reset_n  = d[4];
            got.system_power_ok = d[5];
            got.rail_enable     = d[6];
            got.button_pressed  = d[7];
            got.reset_line_n    = d[8];
            got.cpu_hot         = d[9];
            got.hook_event      = hook_t'(d[12:10]);
            got.radio_mode      = d[14:13];
            got.deep_sleep_ok   = d[15];
            if (reports_due.size() == 0)
            begin
                fail_note();
                if (failures <= REPORT_MAX)
                    $display("%0t: report %h arrived with none outstanding", $realtime, d);
                return;
            end
            due = reports_due.pop_front();
            compared++;
            bad = "";
            if (got.sys_state !== due.sys_state)             bad = {bad, " sys_state"};
            if (got.resume_reset_n !== due.resume_reset_n)   bad = {bad, " resume_reset_n"};
            if (got.system_power_ok !== due.system_power_ok) bad = {bad, " system_power_ok"};
            if (got.rail_enable !== due.rail_enable)         bad = {bad, " rail_enable"};
            if (got.button_pressed !== due.button_pressed)   bad = {bad, " button_pressed"};
            if (got.reset_line_n !== due.reset_line_n)       bad = {bad, " reset_line_n"};
            if (got.cpu_hot !== due.cpu_hot)                 bad = {bad, " cpu_hot"};
            if (got.hook_event !== due.hook_event)           bad = {bad, " hook_event"};
            if (got.radio_mode !== due.radio_mode)           bad = {bad, " radio_mode"};
            if (got.deep_sleep_ok !== due.deep_sleep_ok)     bad = {bad, " deep_sleep_ok"};
            if (bad != "")
            begin
                fail_note();
                if (failures <= REPORT_MAX)
                begin
                    $display("%0t: report %0d differs in%s", $realtime, compared, bad);
                    $write("  wanted st=%0d rsm=%b pok=%b rail=%b btn=%b ",
                        due.sys_state, due.resume_reset_n, due.system_power_ok,
                        due.rail_enable, due.button_pressed);
                    $display("rcin=%b hot=%b hook=%0d radio=%0d ds=%b",
                        due.reset_line_n, due.cpu_hot, due.hook_event,
                        due.radio_mode, due.deep_sleep_ok);
                    $write("  got    st=%0d rsm=%b pok=%b rail=%b btn=%b ",
                        got.sys_state, got.resume_reset_n, got.system_power_ok,
                        got.rail_enable, got.button_pressed);
                    $display("rcin=%b hot=%b hook=%0d radio=%0d ds=%b",
                        got.reset_line_n, got.cpu_hot, got.hook_event,
                        got.radio_mode, got.deep_sleep_ok);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int cycle_count = 0;
    int gap_pct = 0;       // chance of a sender gap before a tick request
    int stall_pct = 0;     // chance per cycle of a result-side stall burst
    int ticks_sent = 0;
    int settings_used = 1;

    sequencer_scoreboard board = new();

    acpi_power_state_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost report ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Monitor: all three channels are sampled with the values they held at the edge.
    // Reports are checked before the same edge's tick request is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_tick(s_tdata);
        end
    end

    // Result-side backpressure: random bursts of stalls on m_tready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // tdata bit order: spok lowest, throttle_request highest.
    function automatic logic [7:0] pins(input logic spok, vgate, s5n, s3n,
                                        input logic up, sd, wr, thr);
        return {thr, wr, sd, up, s3n, s5n, vgate, spok};
    endfunction

    // Present one tick request and hold it until the sequencer takes it.
    task automatic send_tick(input logic [7:0] bits);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tdata  <= bits;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // Leaves cfg_valid high; write_config drops it after the last register.
    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] wait_ticks, pwrok_ticks, pulse_ticks,
                                input logic rail_ctl);
        put_reg(REG_SPOK_WAIT, wait_ticks);
        put_reg(REG_PWROK_DELAY, pwrok_ticks);
        put_reg(REG_RESET_PULSE, pulse_ticks);
        put_reg(REG_G3_RAIL, {15'd0, rail_ctl});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Stop sending and wait until every tick request has reported back.
    // The first edge lets the monitor note the last accepted request.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.reports_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] bits;
        logic spok_lvl, vgate_lvl, s5_lvl, s3_lvl, thr_lvl;
        int drop_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under reset settings: G3 -> S0 and back down to G3,
        // with requests that off states must ignore and a restarted reset pulse.
        send_tick(pins(0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(pins(1, 1, 1, 1, 0, 1, 1, 1));   // no power-up: stays in G3
        send_tick(pins(0, 0, 0, 0, 1, 1, 1, 1));   // power-up request, off-state requests
        send_tick(pins(1, 1, 0, 0, 0, 0, 0, 0));   // G3S5 first tick: pre-init, spok good
        send_tick(pins(1, 1, 1, 0, 0, 0, 0, 0));   // S5 -> S5S3
        send_tick(pins(1, 1, 1, 0, 0, 0, 0, 0));   // startup hook
        send_tick(pins(1, 1, 1, 1, 0, 0, 0, 1));   // S3 -> S3S0, throttle in on state
        send_tick(pins(1, 1, 1, 1, 0, 0, 0, 1));   // resume hook
        send_tick(pins(1, 1, 1, 1, 0, 0, 1, 0));   // warm reset pulse
        send_tick(pins(1, 0, 1, 1, 1, 0, 0, 0));   // vgate drop, stray power-up
        send_tick(pins(1, 1, 1, 1, 0, 0, 1, 1));   // warm reset again restarts the pulse
        send_tick(pins(1, 1, 1, 0, 0, 0, 0, 0));   // S0 -> S0S3
        send_tick(pins(1, 1, 1, 0, 0, 0, 0, 1));   // suspend hook
        send_tick(pins(1, 1, 1, 1, 0, 0, 0, 0));   // S3 -> S3S0
        send_tick(pins(1, 1, 1, 1, 0, 0, 0, 0));   // back in S0
        send_tick(pins(1, 1, 1, 1, 0, 1, 0, 0));   // forced shutdown presses the button
        send_tick(pins(1, 1, 1, 0, 0, 0, 0, 0));   // S0 -> S0S3
        send_tick(pins(1, 1, 0, 0, 0, 0, 0, 0));   // S3
        send_tick(pins(1, 1, 0, 0, 0, 0, 0, 0));   // S3 -> S3S5
        send_tick(pins(1, 1, 0, 0, 0, 0, 0, 1));   // shutdown hook, throttle ignored
        send_tick(pins(1, 1, 0, 0, 0, 0, 0, 0));   // in S5: pending shutdown releases button
        send_tick(pins(0, 1, 0, 0, 0, 0, 0, 0));   // spok lost: S5G3
        send_tick(pins(0, 0, 0, 0, 0, 0, 0, 0));   // G3, rails dropped
        drain_reports();   // hold off until every report is back

        spok_lvl = 1'b1;
        vgate_lvl = 1'b1;
        s5_lvl = 1'b0;
        s3_lvl = 1'b0;
        thr_lvl = 1'b0;

        // Random phases, each under its own register setting; the first three
        // hit both ends of every register, including zero wait and pulse lengths.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_config(16'd0, 16'd0, 16'd0, 1'b0);
                1: write_config(16'd1, 16'hFFFF, 16'd1, 1'b1);
                2: write_config(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
                3: write_config(SPOK_WAIT_RST, PWROK_DELAY_RST, RESET_PULSE_RST, 1'b1);
                default: write_config(16'($urandom_range(1, 12)), 16'($urandom_range(0, 6)),
                                      16'($urandom_range(1, 12)), 1'($urandom_range(0, 1)));
            endcase
            drop_pct = $urandom_range(1, 8);
            // last two phases run with no idling on either side
            if (phase >= PHASES - 2)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = $urandom_range(0, 3) * 10;
                stall_pct = $urandom_range(0, 3) * 8;
            end

            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if ($urandom_range(0, 99) < 8)
                    bits = 8'($urandom_range(0, 255));   // noise
                else
                begin
                    // Slowly moving rail and sleep levels let the walk reach S0.
                    if (spok_lvl)
                        spok_lvl = ($urandom_range(0, 99) >= drop_pct);
                    else
                        spok_lvl = ($urandom_range(0, 99) < 35);
                    if ($urandom_range(0, 99) < 10) vgate_lvl = !vgate_lvl;
                    if ($urandom_range(0, 99) < 12) s5_lvl = !s5_lvl;
                    if ($urandom_range(0, 99) < 12) s3_lvl = !s3_lvl;
                    if ($urandom_range(0, 99) < 20) thr_lvl = !thr_lvl;
                    bits = pins(spok_lvl, vgate_lvl, s5_lvl, s3_lvl,
                                $urandom_range(0, 99) < 25, $urandom_range(0, 99) < 3,
                                $urandom_range(0, 99) < 6, thr_lvl);
                end
                send_tick(bits);
            end
            drain_reports();
        end

        // Let the monitor catch any report sent without a request behind it, then check that none is still due.
        repeat (8) @(posedge clk);
        if (board.reports_due.size() != 0)
        begin
            board.fail_note();
            $display("%0d reports never arrived", board.reports_due.size());
        end

        $display("Run: %0d tick requests under %0d register settings, %0d reports compared.",
                 ticks_sent, settings_used, board.compared);
        $display("Power states reached: %0d of 10; warm-reset pulses started: %0d.",
                 $countones(board.seen_states), board.pulses_started);
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
